@@ hw/rtl/swrm_pkg.sv @@
package swrm_pkg;

    // Sizing of the entry FIFO and the window
    localparam int FIFO_DEPTH = 64;
    localparam int WINDOW_MS  = 5000;
    localparam int MS_PER_S   = 1000;

    localparam int ADDR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W  = $clog2(FIFO_DEPTH + 1);

    // Field widths
    localparam int BYTES_W = 32;
    localparam int TIME_W  = 64;
    localparam int SUM_W   = 38;
    localparam int RATE_W  = 36;
    localparam int ENTRY_W = BYTES_W + TIME_W;

    // Rate divisor: whole seconds in the window, never below one
    localparam int RATE_DIV  = (WINDOW_MS / MS_PER_S == 0) ? 1 : (WINDOW_MS / MS_PER_S);

    // Fixed-point reciprocal of the divisor, exact for every sum below 2^SUM_W
    localparam int DIV_SH    = SUM_W + $clog2(RATE_DIV);
    localparam int RECIP_W   = SUM_W + 1;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << DIV_SH) + 64'(RATE_DIV) - 64'd1) / 64'(RATE_DIV));

    // Halves of the sum and the reciprocal for four partial products
    localparam int X_LO_W    = SUM_W / 2;
    localparam int X_HI_W    = SUM_W - X_LO_W;
    localparam int R_LO_W    = X_LO_W;
    localparam int R_HI_W    = RECIP_W - R_LO_W;
    localparam int PROD_W    = SUM_W + RECIP_W;
    localparam int DIV_STEPS = 4;
    localparam int STEP_W    = 2;

    localparam logic [SUM_W-1:0]  SUM_MAX  = '1;
    localparam logic [RATE_W-1:0] RATE_MAX = '1;

    // Command codes
    localparam logic CMD_DATA   = 1'b0;
    localparam logic CMD_UPDATE = 1'b1;

    typedef struct packed {
        logic               command;
        logic [BYTES_W-1:0] byte_count;
        logic [TIME_W-1:0]  time_ms;
    } t_in_item;

    typedef struct packed {
        logic [RATE_W-1:0] rate_bytes_per_s;
        logic [SUM_W-1:0]  window_bytes;
        logic              entry_dropped;
    } t_out_item;

    // Controller to datapath
    typedef struct packed {
        logic push;
        logic load_now;
        logic rd_head;
        logic pop;
        logic div_start;
        logic div_step;
        logic load_rate;
        logic load_out;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic count_zero;
        logic count_one;
        logic head_expired;
        logic div_last;
    } t_dp_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXP_RD,
        ST_EXP_CHK,
        ST_DIV_INIT,
        ST_DIV,
        ST_RATE,
        ST_DONE
    } t_state;

endpackage

@@ hw/rtl/swrm_ram.sv @@
module swrm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hw/rtl/swrm_ctrl.sv @@
module swrm_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_command,
    output logic                o_in_stall,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    input  swrm_pkg::t_dp_status i_status,
    output swrm_pkg::t_dp_cmd    o_cmd
);

    import swrm_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   in_accept;
    logic   out_free;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_accept   = i_in_valid && (r_state == ST_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;

    // State and output-valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and datapath commands
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    if (i_in_command == CMD_DATA) begin
                        o_cmd.push = 1'b1;
                        n_state    = ST_DONE;
                    end else begin
                        o_cmd.load_now = 1'b1;
                        n_state = i_status.count_zero ? ST_DIV_INIT : ST_EXP_RD;
                    end
                end
            end
            ST_EXP_RD: begin
                o_cmd.rd_head = 1'b1;
                n_state       = ST_EXP_CHK;
            end
            ST_EXP_CHK: begin
                if (i_status.head_expired) begin
                    o_cmd.pop = 1'b1;
                    n_state   = i_status.count_one ? ST_DIV_INIT : ST_EXP_RD;
                end else begin
                    n_state = ST_DIV_INIT;
                end
            end
            ST_DIV_INIT: begin
                o_cmd.div_start = 1'b1;
                n_state         = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = ST_RATE;
                end
            end
            ST_RATE: begin
                o_cmd.load_rate = 1'b1;
                n_state         = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

@@ hw/rtl/swrm_dp.sv @@
module swrm_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  swrm_pkg::t_in_item   i_in_data,
    input  swrm_pkg::t_dp_cmd    i_cmd,
    output swrm_pkg::t_dp_status o_status,
    output swrm_pkg::t_out_item  o_out_data
);

    import swrm_pkg::*;

    logic [ADDR_W-1:0] r_head, n_head;
    logic [ADDR_W-1:0] r_tail, n_tail;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [SUM_W-1:0]  r_sum, n_sum;
    logic [RATE_W-1:0] r_rate, n_rate;
    logic              r_drop, n_drop;
    logic [TIME_W-1:0] r_now;
    logic [PROD_W-1:0] r_acc, n_acc;
    logic [STEP_W-1:0] r_step, n_step;
    t_out_item         r_out;

    logic               fifo_full;
    logic               wr_en;
    logic [ENTRY_W-1:0] rd_entry;
    logic [BYTES_W-1:0] head_bytes;
    logic [TIME_W-1:0]  head_time;
    logic [TIME_W-1:0]  head_age;
    logic [SUM_W:0]     sum_add;
    logic [X_HI_W-1:0]  mul_a;
    logic [R_HI_W-1:0]  mul_b;
    logic [X_HI_W+R_HI_W-1:0] mul_p;
    logic [PROD_W-1:0]  term_x;
    logic [PROD_W-1:0]  mul_term;
    logic [PROD_W-1:0]  quot;

    assign fifo_full = (r_count == CNT_W'(FIFO_DEPTH));
    assign wr_en     = i_cmd.push && !fifo_full;

    swrm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (FIFO_DEPTH)
    ) u_entry_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_tail),
        .i_wr_data ({i_in_data.byte_count, i_in_data.time_ms}),
        .i_rd_en   (i_cmd.rd_head),
        .i_rd_addr (r_head),
        .o_rd_data (rd_entry)
    );

    // Age test on the head entry: too old or stamped in the future
    assign head_bytes = rd_entry[ENTRY_W-1 -: BYTES_W];
    assign head_time  = rd_entry[TIME_W-1:0];
    assign head_age   = r_now - head_time;

    assign o_status.count_zero   = (r_count == '0);
    assign o_status.count_one    = (r_count == CNT_W'(1));
    assign o_status.head_expired = (head_age > TIME_W'(WINDOW_MS)) || (r_now < head_time);
    assign o_status.div_last     = (r_step == STEP_W'(DIV_STEPS - 1));

    assign sum_add = {1'b0, r_sum} + (SUM_W + 1)'(i_in_data.byte_count);

    // One partial product of sum times reciprocal per step, placed at its weight
    assign mul_a    = r_step[1] ? X_HI_W'(r_sum[SUM_W-1:X_LO_W]) : X_HI_W'(r_sum[X_LO_W-1:0]);
    assign mul_b    = r_step[0] ? R_HI_W'(RECIP[RECIP_W-1:R_LO_W]) : R_HI_W'(RECIP[R_LO_W-1:0]);
    assign mul_p    = mul_a * mul_b;
    assign term_x   = r_step[1] ? (PROD_W'(mul_p) << X_LO_W) : PROD_W'(mul_p);
    assign mul_term = r_step[0] ? (term_x << R_LO_W) : term_x;
    assign quot     = r_acc >> DIV_SH;

    // Pointer, count, sum, drop flag, rate and divider updates
    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        n_sum   = r_sum;
        n_rate  = r_rate;
        n_drop  = r_drop;
        n_acc   = r_acc;
        n_step  = r_step;

        if (i_cmd.push) begin
            n_drop = fifo_full;
            if (!fifo_full) begin
                n_tail  = (r_tail == ADDR_W'(FIFO_DEPTH - 1)) ? '0 : r_tail + 1'b1;
                n_count = r_count + 1'b1;
                n_sum   = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
            end
        end
        if (i_cmd.load_now) begin
            n_drop = 1'b0;
        end
        if (i_cmd.pop) begin
            n_head  = (r_head == ADDR_W'(FIFO_DEPTH - 1)) ? '0 : r_head + 1'b1;
            n_count = r_count - 1'b1;
            n_sum   = (r_sum >= SUM_W'(head_bytes)) ? r_sum - SUM_W'(head_bytes) : '0;
        end
        if (i_cmd.div_start) begin
            n_acc  = '0;
            n_step = '0;
        end
        if (i_cmd.div_step) begin
            n_acc  = r_acc + mul_term;
            n_step = r_step + 1'b1;
        end
        if (i_cmd.load_rate) begin
            n_rate = (quot > PROD_W'(RATE_MAX)) ? RATE_MAX : quot[RATE_W-1:0];
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_sum   <= '0;
            r_rate  <= '0;
            r_drop  <= 1'b0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            r_sum   <= n_sum;
            r_rate  <= n_rate;
            r_drop  <= n_drop;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_acc  <= n_acc;
        r_step <= n_step;
        if (i_cmd.load_now) begin
            r_now <= i_in_data.time_ms;
        end
        if (i_cmd.load_out) begin
            r_out.rate_bytes_per_s <= r_rate;
            r_out.window_bytes     <= r_sum;
            r_out.entry_dropped    <= r_drop;
        end
    end

    assign o_out_data = r_out;

endmodule

@@ hw/rtl/sliding_window_rate_meter.sv @@
// Sliding-window rate meter. A data beat (command 0) appends its byte count and
// millisecond stamp to a 64-entry FIFO and adds the count to the window sum,
// which saturates; when the FIFO is full the beat is dropped and entry_dropped
// is set. An update beat (command 1) expires entries from the head while they
// are more than 5000 ms older than its time or stamped after it, subtracts
// them from the sum (never below zero), and recomputes rate = sum / 5. Every
// beat returns one result with the stored rate and sum. An update beat checks
// the head entries one at a time, since each check waits on the entry RAM's
// registered read, until the FIFO is empty or the scan stops at an entry
// still in the window. The divide by the window length in seconds multiplies
// the sum by a fixed-point reciprocal, one of four partial products per cycle.
// A stalled result holds the block in its last cycle until the output register
// frees. A new beat is taken while the previous result still waits in the
// output register; no clearing pass is needed after reset.
module sliding_window_rate_meter (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  swrm_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output swrm_pkg::t_out_item  o_out_data
);

    import swrm_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    swrm_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_command (i_in_data.command),
        .o_in_stall   (o_in_stall),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_status     (status),
        .o_cmd        (cmd)
    );

    swrm_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_out_data (o_out_data)
    );

endmodule

@@ tb/sliding_window_rate_meter_test.sv @@
module sliding_window_rate_meter_test;
    timeunit 1ns;
    timeprecision 1ps;

    import swrm_pkg::*;

    localparam int RING_AW = 12;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_item  in_beat = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_beat;

    // Stimulus and scoreboard rings
    t_in_item           pending_beats [2**RING_AW];
    logic [RING_AW-1:0] pend_wr = '0;
    logic [RING_AW-1:0] pend_rd = '0;
    t_out_item          expected_results [2**RING_AW];
    logic [RING_AW-1:0] exp_wr = '0;
    logic [RING_AW-1:0] exp_rd = '0;
    t_out_item          want_result;

    int        idle_pct = 0;
    int        stall_pct = 0;
    bit        failed = 1'b0;

    // Shadow copy of the meter state
    logic [BYTES_W-1:0] store_bytes [FIFO_DEPTH];
    logic [TIME_W-1:0]  store_stamp [FIFO_DEPTH];
    logic [ADDR_W-1:0]  store_head = '0;
    logic [ADDR_W-1:0]  store_tail = '0;
    int unsigned        stored_cnt = 0;
    logic [SUM_W-1:0]   window_total = '0;
    logic [RATE_W-1:0]  held_rate = '0;

    // Running timestamp for well-formed traffic
    logic [TIME_W-1:0]  gen_now = '0;
    int                 queued_cnt = 0;

    sliding_window_rate_meter u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_beat),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_beat)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Apply one beat to the shadow state and return the result it should produce
    function automatic t_out_item predict_meter(input t_in_item beat);
        t_out_item          res;
        logic [SUM_W:0]     grown;
        logic [SUM_W-1:0]   quot;
        logic [TIME_W-1:0]  age;
        logic [TIME_W-1:0]  head_stamp;
        bit                 scanning;
        res = '0;
        if (beat.command == CMD_DATA) begin
            if (stored_cnt >= FIFO_DEPTH) begin
                res.entry_dropped = 1'b1;
            end else begin
                store_bytes[store_tail] = beat.byte_count;
                store_stamp[store_tail] = beat.time_ms;
                store_tail = (store_tail == ADDR_W'(FIFO_DEPTH - 1)) ? '0 : store_tail + 1'b1;
                stored_cnt++;
                grown = {1'b0, window_total} + (SUM_W+1)'(beat.byte_count);
                window_total = (grown > {1'b0, SUM_MAX}) ? SUM_MAX : grown[SUM_W-1:0];
            end
        end else begin
            // Expire from the head while too old or stamped in the future
            scanning = 1'b1;
            while (scanning && stored_cnt > 0) begin
                head_stamp = store_stamp[store_head];
                age = beat.time_ms - head_stamp;
                if (age > TIME_W'(WINDOW_MS) || beat.time_ms < head_stamp) begin
                    if (window_total >= SUM_W'(store_bytes[store_head])) begin
                        window_total = window_total - SUM_W'(store_bytes[store_head]);
                    end else begin
                        window_total = '0;
                    end
                    store_head = (store_head == ADDR_W'(FIFO_DEPTH - 1)) ? '0 :
                                 store_head + 1'b1;
                    stored_cnt--;
                end else begin
                    scanning = 1'b0;
                end
            end
            quot = window_total / SUM_W'(RATE_DIV);
            held_rate = (quot > SUM_W'(RATE_MAX)) ? RATE_MAX : quot[RATE_W-1:0];
        end
        res.rate_bytes_per_s = held_rate;
        res.window_bytes     = window_total;
        return res;
    endfunction

    function automatic logic [BYTES_W-1:0] pick_bytes();
        case ($urandom_range(5))
            0: pick_bytes = '0;
            1: pick_bytes = '1;
            2: pick_bytes = $urandom;
            default: pick_bytes = $urandom_range(2000);
        endcase
    endfunction

    task automatic queue_beat(input logic cmd, input logic [BYTES_W-1:0] bytes,
                              input logic [TIME_W-1:0] stamp);
        t_in_item beat;
        beat.command    = cmd;
        beat.byte_count = bytes;
        beat.time_ms    = stamp;
        pending_beats[pend_wr] = beat;
        pend_wr = pend_wr + 1'b1;
        queued_cnt++;
    endtask

    // Ordinary traffic: mostly data with occasional updates, time moving forward
    task automatic add_traffic_run();
        int n;
        n = $urandom_range(5, 30);
        repeat (n) begin
            case ($urandom_range(11))
                0: gen_now = gen_now + $urandom_range(4000, 7000);
                1: queue_beat(CMD_UPDATE, $urandom,
                              gen_now + WINDOW_MS + $urandom_range(1));
                2: queue_beat(CMD_UPDATE, $urandom, gen_now - $urandom_range(1, 3000));
                default: gen_now = gen_now + $urandom_range(400);
            endcase
            if ($urandom_range(9) < 7) begin
                queue_beat(CMD_DATA, pick_bytes(), gen_now);
            end else begin
                queue_beat(CMD_UPDATE, $urandom, gen_now);
            end
        end
    endtask

    // Burst of 60 to 75 data beats, which can fill the FIFO and force drops
    task automatic add_fill_burst();
        int n;
        n = $urandom_range(60, 75);
        repeat (n) begin
            gen_now = gen_now + $urandom_range(3);
            queue_beat(CMD_DATA, pick_bytes(), gen_now);
        end
        if ($urandom_range(1)) begin
            queue_beat(CMD_UPDATE, $urandom, gen_now + $urandom_range(6000));
        end
    endtask

    // Unstructured beats with fully random fields
    task automatic add_noise();
        int n;
        n = $urandom_range(1, 6);
        repeat (n) begin
            queue_beat(1'($urandom_range(1)), $urandom, {$urandom, $urandom});
        end
        case ($urandom_range(3))
            0: gen_now = {$urandom, $urandom};
            1: gen_now = 64'hFFFF_FFFF_FFFF_F000 + $urandom_range(4000);
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (pend_wr != pend_rd || in_valid || exp_wr != exp_rd) begin
            @(negedge clk);
        end
    endtask

    // Drive beats from the pending ring, predicting each one as it is taken
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || !in_stall) begin
            if (in_valid) begin
                expected_results[exp_wr] = predict_meter(in_beat);
                exp_wr = exp_wr + 1'b1;
            end
            if (pend_wr != pend_rd && $urandom_range(99) >= idle_pct) begin
                in_beat  <= pending_beats[pend_rd];
                in_valid <= 1'b1;
                pend_rd = pend_rd + 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Throttle the result side
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Compare each result beat against the oldest prediction
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (exp_wr == exp_rd) begin
                $error("result beat with no prediction pending");
                failed = 1'b1;
            end else begin
                want_result = expected_results[exp_rd];
                exp_rd = exp_rd + 1'b1;
                if (out_beat.rate_bytes_per_s !== want_result.rate_bytes_per_s) begin
                    $error("rate_bytes_per_s: expected %0d, actual %0d",
                           want_result.rate_bytes_per_s, out_beat.rate_bytes_per_s);
                    failed = 1'b1;
                end
                if (out_beat.window_bytes !== want_result.window_bytes) begin
                    $error("window_bytes: expected %0d, actual %0d",
                           want_result.window_bytes, out_beat.window_bytes);
                    failed = 1'b1;
                end
                if (out_beat.entry_dropped !== want_result.entry_dropped) begin
                    $error("entry_dropped: expected %0d, actual %0d",
                           want_result.entry_dropped, out_beat.entry_dropped);
                    failed = 1'b1;
                end
            end
        end
    end

    initial begin
        int phase;
        int target;
        int pick;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty update, window boundary, future stamps, time wrap
        queue_beat(CMD_UPDATE, '1, '0);
        queue_beat(CMD_DATA, '0, '0);
        queue_beat(CMD_DATA, '1, 64'd100);
        queue_beat(CMD_DATA, 32'd12345, 64'd5000);
        queue_beat(CMD_UPDATE, '0, 64'd5000);
        queue_beat(CMD_UPDATE, '0, 64'd5001);
        queue_beat(CMD_UPDATE, '0, 64'd5100);
        queue_beat(CMD_UPDATE, '0, 64'd5101);
        queue_beat(CMD_UPDATE, '0, 64'd4000);
        queue_beat(CMD_DATA, 32'h8000_0001, 64'hFFFF_FFFF_FFFF_FFF0);
        queue_beat(CMD_DATA, 32'd1, '1);
        queue_beat(CMD_UPDATE, $urandom, '1);
        queue_beat(CMD_UPDATE, '0, 64'd10);
        queue_beat(CMD_DATA, 32'd7, 64'h8000_0000_0000_0000);
        queue_beat(CMD_DATA, '1, 64'h8000_0000_0000_0000);
        queue_beat(CMD_UPDATE, '0, 64'h7FFF_FFFF_FFFF_FFFF);
        queue_beat(CMD_DATA, 32'h7FFF_FFFF, 64'h5555_5555_5555_5555);
        queue_beat(CMD_DATA, 32'hAAAA_AAAA, 64'h5555_5555_5555_5555);
        queue_beat(CMD_UPDATE, '1, 64'h5555_5555_5555_6000);
        queue_beat(CMD_UPDATE, '0, 64'hAAAA_AAAA_AAAA_AAAA);

        // Hold the sender until every directed result is back
        wait_drained();

        // Random phases: no idling, sender idle, receiver stall, both
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 71; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 71; end
                default: begin idle_pct = 35; stall_pct = 35; end
            endcase
            target = queued_cnt + 420;
            while (queued_cnt < target) begin
                pick = $urandom_range(99);
                if (pick < 65) begin
                    add_traffic_run();
                end else if (pick < 80) begin
                    add_fill_burst();
                end else begin
                    add_noise();
                end
            end
            @(negedge clk);
            while (pend_wr != pend_rd) begin
                @(negedge clk);
            end
        end

        // Drain, then allow time for any stray result
        wait_drained();
        repeat (200) @(negedge clk);
        if (!failed && exp_wr == exp_rd) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #10_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
